// ----- rtl/mrs_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mrs_pkg
// Shared types, microcode program and sigmoid table of the perceptron trainer.
// ----------------------------------------------------------------------------
package mrs_pkg;

  localparam int HIDDEN_WIDTH_DEF  = 4;
  localparam int HIDDEN_LAYERS_DEF = 2;
  localparam int WEIGHT_BITS_DEF   = 16;

  localparam int          ONE_Q12         = 4096;
  localparam logic [15:0] STEP_RATE_RESET = 16'd9830;

  localparam int UPC_W = 5;
  typedef logic [UPC_W-1:0] upc_t;

  typedef enum logic [1:0] {
    MODE_LOAD  = 2'd0,
    MODE_TRAIN = 2'd1,
    MODE_INFER = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    SH_11,
    SH_12,
    SH_16
  } shift_t;

  typedef enum logic [4:0] {
    UOP_IDLE,
    UOP_FINIT,
    UOP_FRD_B,
    UOP_FBIAS,
    UOP_FRD,
    UOP_FMAC,
    UOP_FSTORE,
    UOP_SIG,
    UOP_ERR,
    UOP_DO1,
    UOP_DO2,
    UOP_BINIT,
    UOP_BRD,
    UOP_BMAC,
    UOP_BSTORE,
    UOP_UINIT,
    UOP_URD,
    UOP_UG,
    UOP_UW,
    UOP_DONE
  } uop_t;

  typedef enum logic [3:0] {
    C_NEXT,
    C_IDLE,
    C_INFER,
    C_K_MORE,
    C_F_MORE,
    C_J_MORE,
    C_B_MORE,
    C_U_MORE,
    C_DONE
  } cond_t;

  typedef struct packed {
    uop_t  uop;
    cond_t cond;
    upc_t  target;
  } ctrl_t;

  typedef struct packed {
    logic start;
    logic work;
    logic infer;
    logic k_more;
    logic f_more;
    logic j_more;
    logic b_more;
    logic u_more;
    logic out_free;
  } seq_flags_t;

  localparam upc_t PC_IDLE  = 5'd0;
  localparam upc_t PC_FRD_B = 5'd2;
  localparam upc_t PC_FRD   = 5'd4;
  localparam upc_t PC_BRD   = 5'd12;
  localparam upc_t PC_URD   = 5'd16;
  localparam upc_t PC_DONE  = 5'd19;

  // Microprogram: one control word per step.
  function automatic ctrl_t ucode(input upc_t pc);
    ctrl_t c;
    c = '{uop: UOP_IDLE, cond: C_IDLE, target: PC_DONE};
    unique case (pc)
      5'd0:    c = '{uop: UOP_IDLE,   cond: C_IDLE,   target: PC_DONE};
      5'd1:    c = '{uop: UOP_FINIT,  cond: C_NEXT,   target: PC_IDLE};
      5'd2:    c = '{uop: UOP_FRD_B,  cond: C_NEXT,   target: PC_IDLE};
      5'd3:    c = '{uop: UOP_FBIAS,  cond: C_NEXT,   target: PC_IDLE};
      5'd4:    c = '{uop: UOP_FRD,    cond: C_NEXT,   target: PC_IDLE};
      5'd5:    c = '{uop: UOP_FMAC,   cond: C_K_MORE, target: PC_FRD};
      5'd6:    c = '{uop: UOP_FSTORE, cond: C_F_MORE, target: PC_FRD_B};
      5'd7:    c = '{uop: UOP_SIG,    cond: C_NEXT,   target: PC_IDLE};
      5'd8:    c = '{uop: UOP_ERR,    cond: C_INFER,  target: PC_DONE};
      5'd9:    c = '{uop: UOP_DO1,    cond: C_NEXT,   target: PC_IDLE};
      5'd10:   c = '{uop: UOP_DO2,    cond: C_NEXT,   target: PC_IDLE};
      5'd11:   c = '{uop: UOP_BINIT,  cond: C_NEXT,   target: PC_IDLE};
      5'd12:   c = '{uop: UOP_BRD,    cond: C_NEXT,   target: PC_IDLE};
      5'd13:   c = '{uop: UOP_BMAC,   cond: C_J_MORE, target: PC_BRD};
      5'd14:   c = '{uop: UOP_BSTORE, cond: C_B_MORE, target: PC_BRD};
      5'd15:   c = '{uop: UOP_UINIT,  cond: C_NEXT,   target: PC_IDLE};
      5'd16:   c = '{uop: UOP_URD,    cond: C_NEXT,   target: PC_IDLE};
      5'd17:   c = '{uop: UOP_UG,     cond: C_NEXT,   target: PC_IDLE};
      5'd18:   c = '{uop: UOP_UW,     cond: C_U_MORE, target: PC_URD};
      5'd19:   c = '{uop: UOP_DONE,   cond: C_DONE,   target: PC_IDLE};
      default: c = '{uop: UOP_IDLE,   cond: C_IDLE,   target: PC_DONE};
    endcase
    return c;
  endfunction

  // round(4096 * sigmoid(x)) at x = 0, 0.5, ... 8.0
  function automatic logic [12:0] sig_lut(input logic [4:0] i);
    logic [12:0] v;
    v = 13'd4095;
    unique case (i)
      5'd0:    v = 13'd2048;
      5'd1:    v = 13'd2550;
      5'd2:    v = 13'd2994;
      5'd3:    v = 13'd3349;
      5'd4:    v = 13'd3608;
      5'd5:    v = 13'd3785;
      5'd6:    v = 13'd3902;
      5'd7:    v = 13'd3976;
      5'd8:    v = 13'd4022;
      5'd9:    v = 13'd4051;
      5'd10:   v = 13'd4069;
      5'd11:   v = 13'd4079;
      5'd12:   v = 13'd4086;
      5'd13:   v = 13'd4090;
      5'd14:   v = 13'd4092;
      5'd15:   v = 13'd4094;
      default: v = 13'd4095;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/mrs_mul.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mrs_mul
// Shared signed multiplier with round-half-up right shift.
// ----------------------------------------------------------------------------
module mrs_mul #(
  parameter int OPW = 21
) (
  input  wire logic signed [OPW-1:0]   mul_a,
  input  wire logic signed [OPW-1:0]   mul_b,
  input  wire mrs_pkg::shift_t         shift_sel,
  output logic signed      [2*OPW-1:0] mul_out
);
  import mrs_pkg::*;

  logic signed [2*OPW-1:0] prod;

  always_comb begin
    prod = mul_a * mul_b;
    unique case (shift_sel)
      SH_11:   mul_out = (prod + (2*OPW)'(1 << 10)) >>> 11;
      SH_12:   mul_out = (prod + (2*OPW)'(1 << 11)) >>> 12;
      SH_16:   mul_out = (prod + (2*OPW)'(1 << 15)) >>> 16;
      default: mul_out = (prod + (2*OPW)'(1 << 11)) >>> 12;
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/mrs_seq.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mrs_seq
// Microprogram counter with conditional jumps over the control ROM.
// ----------------------------------------------------------------------------
module mrs_seq (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire mrs_pkg::seq_flags_t flags,
  output mrs_pkg::ctrl_t           ctrl
);
  import mrs_pkg::*;

  upc_t upc_r, upc_nxt;

  assign ctrl = ucode(upc_r);

  always_comb begin
    upc_nxt = upc_r + 1'b1;
    unique case (ctrl.cond)
      C_NEXT: upc_nxt = upc_r + 1'b1;
      C_IDLE: begin
        if (!flags.start) upc_nxt = upc_r;
        else if (!flags.work) upc_nxt = ctrl.target;
      end
      C_INFER:  if (flags.infer)  upc_nxt = ctrl.target;
      C_K_MORE: if (flags.k_more) upc_nxt = ctrl.target;
      C_F_MORE: if (flags.f_more) upc_nxt = ctrl.target;
      C_J_MORE: if (flags.j_more) upc_nxt = ctrl.target;
      C_B_MORE: if (flags.b_more) upc_nxt = ctrl.target;
      C_U_MORE: if (flags.u_more) upc_nxt = ctrl.target;
      C_DONE:   upc_nxt = flags.out_free ? ctrl.target : upc_r;
      default:  upc_nxt = PC_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= PC_IDLE;
    end else begin
      upc_r <= upc_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/mlp_relu_sigmoid_trainer.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mlp_relu_sigmoid_trainer
// 2-H-..-H-1 perceptron (ReLU hidden, table sigmoid out) with on-chip SGD.
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake             Contents
// in_      in   in_tvalid/in_tready   tuser mode; tdata slot, value, bits
// out_     out  out_tvalid/out_tready tdata level, bit, squared error
// cfg_     in   cfg_wr_en             step_rate, Q0.16
//
// A microprogram drives one shared multiplier, the weight memory and small
// activation/gradient register files. Load and unused-mode items go from the
// idle step to the done step. Infer takes read and multiply steps per forward
// product and bias read, bias and store steps per neuron; train adds read and
// multiply steps per backward product and read, gradient and write steps per
// weight. Reset is synchronous and clears only control state; weights must be
// loaded. An item is taken while a finished result waits; the last step holds
// until the output register is free, so out_tready stalls only that step.
// ----------------------------------------------------------------------------
module mlp_relu_sigmoid_trainer #(
  parameter int HIDDEN_WIDTH  = mrs_pkg::HIDDEN_WIDTH_DEF,
  parameter int HIDDEN_LAYERS = mrs_pkg::HIDDEN_LAYERS_DEF,
  parameter int WEIGHT_BITS   = mrs_pkg::WEIGHT_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [5:0] weight_slot, [21:6] weight_value, [22] first_bit, [23] second_bit,
  // [24] target_bit, [25] chain_previous
  input  wire logic [31:0] in_tdata,
  // [1:0] mode
  input  wire logic [1:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [12:0] output_level, [13] output_bit, [26:14] squared_error
  output logic [31:0]      out_tdata,
  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data
);
  import mrs_pkg::*;

  localparam int H      = HIDDEN_WIDTH;
  localparam int L      = HIDDEN_LAYERS;
  localparam int WB     = WEIGHT_BITS;
  localparam int NODES  = H * L;
  localparam int WCOUNT = 3 * H + (L - 1) * (H + 1) * H + H + 1;
  localparam int AW     = $clog2(WCOUNT);
  localparam int NW     = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int GW     = $clog2(NODES + 1);
  localparam int LW     = $clog2(L + 1);
  localparam int JW     = (H > 1) ? $clog2(H) : 1;
  localparam int KMAX   = (H > 2) ? H : 2;
  localparam int KW     = $clog2(KMAX + 1);
  localparam int OPW    = (2 * WB - 11 > 18) ? 2 * WB - 11 : 18;
  localparam int MOW    = 2 * OPW;
  localparam int ACCW   = OPW + 6;
  localparam int ZAW    = (WB + 1 > 16) ? WB + 1 : 16;
  localparam int GRW    = (WB > 14) ? WB : 14;

  // Clamp to the weight range.
  function automatic logic signed [WB-1:0] sat_wb(input logic signed [ACCW-1:0] v);
    logic signed [ACCW-1:0] hi;
    logic signed [ACCW-1:0] lo;
    hi = {{(ACCW - WB + 1){1'b0}}, {(WB - 1){1'b1}}};
    lo = ~hi;
    if (v > hi) return hi[WB-1:0];
    if (v < lo) return lo[WB-1:0];
    return v[WB-1:0];
  endfunction

  function automatic int lbase(input int l);
    return (l == 0) ? 0 : 3 * H + (l - 1) * (H + 1) * H;
  endfunction

  function automatic int nodes_of(input int l);
    return (l == L) ? 1 : H;
  endfunction

  function automatic int delta_idx(input int l, input int j);
    return (l == L) ? NODES : l * H + j;
  endfunction

  // Sequencer
  ctrl_t      ctrl;
  seq_flags_t flags;
  uop_t       uop;

  mrs_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .ctrl  (ctrl)
  );

  assign uop = ctrl.uop;

  // Control and configuration registers
  logic        out_valid_r, out_valid_nxt;
  logic        last_bit_r, last_bit_nxt;
  logic [15:0] step_rate_r;

  // Item and datapath registers
  mode_t                  mode_r;
  logic                   x0_r, x1_r, tgt_r;
  logic [LW-1:0]          l_r, l_nxt;
  logic [JW-1:0]          j_r, j_nxt;
  logic [KW-1:0]          k_r, k_nxt;
  logic signed [ACCW-1:0] acc_r, acc_nxt;
  logic signed [OPW-1:0]  g_r, g_nxt;
  logic signed [WB-1:0]   outz_r, outz_nxt;
  logic [12:0]            y_r, y_nxt;
  logic signed [13:0]     e_r, e_nxt;
  logic [12:0]            sq_r, sq_nxt;
  logic [12:0]            out_level_r;
  logic                   out_bit_r;
  logic [12:0]            out_sq_r;

  // Storage
  logic signed [WB-1:0]  wmem [WCOUNT];
  logic signed [WB-1:0]  rdata_r;
  logic signed [WB-1:0]  act_r [NODES];
  logic signed [GRW-1:0] grad_r [NODES+1];

  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic signed [WB-1:0]  mem_wdata;
  logic [AW-1:0]         mem_raddr;
  logic                  act_we;
  logic [NW-1:0]         act_wi;
  logic signed [WB-1:0]  act_wd;
  logic                  grad_we;
  logic [GW-1:0]         grad_wi;
  logic signed [GRW-1:0] grad_wd;

  // Shared multiplier
  logic signed [OPW-1:0] mul_a, mul_b;
  shift_t                shift_sel;
  logic signed [MOW-1:0] mul_out;
  logic signed [ACCW-1:0] mul_acc;

  mrs_mul #(.OPW(OPW)) u_mul (
    .mul_a     (mul_a),
    .mul_b     (mul_b),
    .shift_sel (shift_sel),
    .mul_out   (mul_out)
  );

  assign mul_acc = $signed(mul_out[ACCW-1:0]);

  // Handshakes
  logic in_fire;
  logic done_fire;
  logic out_free;
  logic work_in;

  assign in_tready = (uop == UOP_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign done_fire = (uop == UOP_DONE) && out_free;
  assign work_in   = (mode_t'(in_tuser) == MODE_TRAIN) || (mode_t'(in_tuser) == MODE_INFER);

  // Loop indices as integers
  int li, ji, ki, fin_i;
  int f_addr, b_addr, u_addr, rd_i;
  int ai, gi;
  logic j_last, k_last_h, k_at_fin;

  logic signed [WB-1:0]  act_rd;
  logic signed [GRW-1:0] grad_rd;
  logic signed [OPW-1:0] in_val;

  // Sigmoid terms
  logic [ZAW-1:0] za;
  logic           z_neg, z_big;
  logic [4:0]     sidx;
  logic [12:0]    sv0, sv1, sv;
  logic signed [13:0] e_c;
  logic signed [ACCW-1:0] upd;

  always_comb begin
    li    = int'(l_r);
    ji    = int'(j_r);
    ki    = int'(k_r);
    fin_i = (l_r == '0) ? 2 : H;

    f_addr = lbase(li) + ((l_r == '0) ? ji * 3 : ji * (H + 1))
           + ((uop == UOP_FRD_B) ? fin_i : ki);
    b_addr = lbase(li + 1) + ji * (H + 1) + ki;
    u_addr = lbase(li) + ((l_r == '0) ? ji * 3 : ji * (H + 1)) + ki;

    unique case (uop)
      UOP_FRD_B, UOP_FRD: rd_i = f_addr;
      UOP_BRD:            rd_i = b_addr;
      default:            rd_i = u_addr;
    endcase
    mem_raddr = AW'(rd_i);

    ai = (uop == UOP_BSTORE) ? li * H + ki : (li - 1) * H + ki;
    gi = (uop == UOP_BMAC) ? delta_idx(li + 1, ji) : delta_idx(li, ji);
    act_rd  = act_r[NW'(ai)];
    grad_rd = grad_r[GW'(gi)];

    if (l_r == '0) begin
      in_val = ((k_r[0] ? x1_r : x0_r)) ? OPW'(ONE_Q12) : '0;
    end else begin
      in_val = (act_rd < 0) ? '0 : OPW'(act_rd);
    end

    j_last   = (ji == nodes_of(li) - 1);
    k_last_h = (ki == H - 1);
    k_at_fin = (ki == fin_i);

    za    = outz_r[WB-1] ? ZAW'(-(ZAW'(outz_r))) : ZAW'(outz_r);
    z_neg = outz_r[WB-1];
    z_big = (int'(za) >= 8 * ONE_Q12);
    sidx  = {1'b0, za[14:11]};
    sv0   = sig_lut(sidx);
    sv1   = sig_lut(sidx + 5'd1);

    e_c = $signed({1'b0, y_r}) - (tgt_r ? 14'sd4096 : 14'sd0);
    sv  = '0;
    upd = '0;

    // defaults
    l_nxt    = l_r;
    j_nxt    = j_r;
    k_nxt    = k_r;
    acc_nxt  = acc_r;
    g_nxt    = g_r;
    outz_nxt = outz_r;
    y_nxt    = y_r;
    e_nxt    = e_r;
    sq_nxt   = sq_r;
    mul_a    = OPW'($signed(rdata_r));
    mul_b    = in_val;
    shift_sel = SH_12;
    act_we   = 1'b0;
    act_wi   = NW'(li * H + ji);
    act_wd   = sat_wb(acc_r);
    grad_we  = 1'b0;
    grad_wi  = GW'(li * H + ki);
    grad_wd  = '0;
    mem_we   = 1'b0;
    mem_waddr = AW'(u_addr);
    mem_wdata = '0;

    flags          = '0;
    flags.start    = in_fire;
    flags.work     = work_in;
    flags.infer    = (mode_r == MODE_INFER);
    flags.k_more   = (ki != fin_i - 1);
    flags.f_more   = !(j_last && (li == L));
    flags.j_more   = (ji != nodes_of(li + 1) - 1);
    flags.b_more   = !(k_last_h && (l_r == '0));
    flags.u_more   = !(k_at_fin && j_last && (li == L));
    flags.out_free = out_free;

    unique case (uop)
      UOP_FINIT, UOP_UINIT: begin
        l_nxt = '0;
        j_nxt = '0;
        k_nxt = '0;
      end
      UOP_FBIAS: begin
        acc_nxt = ACCW'(rdata_r);
        k_nxt   = '0;
      end
      UOP_FMAC: begin
        acc_nxt = acc_r + mul_acc;
        k_nxt   = k_r + 1'b1;
      end
      UOP_FSTORE: begin
        // hold the output pre-activation, keep hidden ones in the scratch
        if (li == L) outz_nxt = sat_wb(acc_r);
        else act_we = 1'b1;
        if (j_last) begin
          j_nxt = '0;
          l_nxt = l_r + 1'b1;
        end else begin
          j_nxt = j_r + 1'b1;
        end
      end
      UOP_SIG: begin
        mul_a     = OPW'($signed({1'b0, sv1 - sv0}));
        mul_b     = OPW'($signed({1'b0, za[10:0]}));
        shift_sel = SH_11;
        sv        = z_big ? 13'd4095 : sv0 + mul_out[12:0];
        y_nxt     = z_neg ? 13'd4096 - sv : sv;
      end
      UOP_ERR: begin
        mul_a  = OPW'(e_c);
        mul_b  = OPW'(e_c);
        e_nxt  = e_c;
        sq_nxt = mul_out[12:0];
      end
      UOP_DO1: begin
        mul_a = OPW'(e_r);
        mul_b = OPW'($signed({1'b0, y_r}));
        g_nxt = mul_out[OPW-1:0];
      end
      UOP_DO2: begin
        mul_a   = g_r;
        mul_b   = OPW'($signed({1'b0, 13'd4096 - y_r}));
        grad_we = 1'b1;
        grad_wi = GW'(NODES);
        grad_wd = mul_out[GRW-1:0];
      end
      UOP_BINIT: begin
        l_nxt   = LW'(L - 1);
        j_nxt   = '0;
        k_nxt   = '0;
        acc_nxt = '0;
      end
      UOP_BMAC: begin
        mul_b   = OPW'(grad_rd);
        acc_nxt = acc_r + mul_acc;
        if (flags.j_more) j_nxt = j_r + 1'b1;
      end
      UOP_BSTORE: begin
        // drop the gradient where the neuron was cut off by ReLU
        grad_we = 1'b1;
        grad_wd = (act_rd < 0) ? '0 : GRW'(sat_wb(acc_r));
        acc_nxt = '0;
        j_nxt   = '0;
        if (k_last_h) begin
          k_nxt = '0;
          l_nxt = l_r - 1'b1;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      UOP_UG: begin
        mul_a = OPW'(grad_rd);
        g_nxt = k_at_fin ? OPW'(grad_rd) : mul_out[OPW-1:0];
      end
      UOP_UW: begin
        mul_a     = OPW'($signed({1'b0, step_rate_r}));
        mul_b     = g_r;
        shift_sel = SH_16;
        upd       = ACCW'(rdata_r) - mul_acc;
        mem_we    = 1'b1;
        mem_wdata = sat_wb(upd);
        if (k_at_fin) begin
          k_nxt = '0;
          if (j_last) begin
            j_nxt = '0;
            l_nxt = l_r + 1'b1;
          end else begin
            j_nxt = j_r + 1'b1;
          end
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      default: ;
    endcase

    // a load is written straight away at accept
    if (in_fire && (mode_t'(in_tuser) == MODE_LOAD)
        && (32'(in_tdata[5:0]) < WCOUNT)) begin
      mem_we    = 1'b1;
      mem_waddr = AW'(in_tdata[5:0]);
      mem_wdata = sat_wb(ACCW'($signed(in_tdata[21:6])));
    end

    out_valid_nxt = done_fire ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
    last_bit_nxt  = last_bit_r;
    if (done_fire && ((mode_r == MODE_TRAIN) || (mode_r == MODE_INFER))) begin
      last_bit_nxt = (y_r >= 13'd2048);
    end
  end

  // Weight memory: one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) wmem[mem_waddr] <= mem_wdata;
    rdata_r <= wmem[mem_raddr];
  end

  // Scratch register files
  always_ff @(posedge clk) begin
    if (act_we) act_r[act_wi] <= act_wd;
    if (grad_we) grad_r[grad_wi] <= grad_wd;
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    l_r    <= l_nxt;
    j_r    <= j_nxt;
    k_r    <= k_nxt;
    acc_r  <= acc_nxt;
    g_r    <= g_nxt;
    outz_r <= outz_nxt;
    y_r    <= y_nxt;
    e_r    <= e_nxt;
    sq_r   <= sq_nxt;
    if (in_fire) begin
      mode_r <= mode_t'(in_tuser);
      x0_r   <= in_tdata[25] ? last_bit_r : in_tdata[22];
      x1_r   <= in_tdata[23];
      tgt_r  <= in_tdata[24];
    end
    if (done_fire) begin
      // load and unused modes report all zero
      out_level_r <= ((mode_r == MODE_TRAIN) || (mode_r == MODE_INFER)) ? y_r : '0;
      out_bit_r   <= ((mode_r == MODE_TRAIN) || (mode_r == MODE_INFER))
                     && (y_r >= 13'd2048);
      out_sq_r    <= (mode_r == MODE_TRAIN) ? sq_r : '0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      last_bit_r  <= 1'b0;
      step_rate_r <= STEP_RATE_RESET;
    end else begin
      out_valid_r <= out_valid_nxt;
      last_bit_r  <= last_bit_nxt;
      if (cfg_wr_en) step_rate_r <= cfg_wr_data;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_sq_r, out_bit_r, out_level_r};

endmodule
`default_nettype wire
